FILE: rtl/core/hmwm_pkg.sv
// shared types and constants for the height map window maximum block
// no dependencies; imported by every module of the block

package hmwm_pkg;

  // input item kinds carried on s_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_GRID_ROWS  = 2'd0;
  localparam logic [1:0] REG_GRID_COLS  = 2'd1;
  localparam logic [1:0] REG_ROW_RADIUS = 2'd2;
  localparam logic [1:0] REG_COL_RADIUS = 2'd3;

  // field widths fixed by the item format
  localparam int COORD_BITS  = 9;
  localparam int RADIUS_BITS = 8;
  localparam int BOUND_BITS  = 10;  // holds coordinate plus radius
  localparam int CFG_BITS    = 9;

  // parameter defaults
  localparam int DEF_MAX_ROWS    = 256;
  localparam int DEF_MAX_COLS    = 256;
  localparam int DEF_HEIGHT_BITS = 16;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // -1.0 in Q8.8
  localparam int SENTINEL_Q88 = -256;

  // register reset values
  localparam logic [8:0] RST_GRID_ROWS  = 9'd256;
  localparam logic [8:0] RST_GRID_COLS  = 9'd256;
  localparam logic [7:0] RST_ROW_RADIUS = 8'd4;
  localparam logic [7:0] RST_COL_RADIUS = 8'd4;

  typedef struct packed {
    logic [CFG_BITS-1:0]    grid_rows;
    logic [CFG_BITS-1:0]    grid_cols;
    logic [RADIUS_BITS-1:0] row_radius;
    logic [RADIUS_BITS-1:0] col_radius;
  } cfg_t;

  // one command for the back end; a write keeps its cell in r_lo / c_lo
  typedef struct packed {
    logic                  query;
    logic [BOUND_BITS-1:0] r_lo;
    logic [BOUND_BITS-1:0] r_hi;
    logic [BOUND_BITS-1:0] c_lo;
    logic [BOUND_BITS-1:0] c_hi;
  } cmd_t;

endpackage

FILE: rtl/core/hmwm_front.sv
// front end: accepts input items, drops writes outside the grid and
// clips query windows to the grid; depends on hmwm_pkg

module hmwm_front import hmwm_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    op,
  input  logic [COORD_BITS-1:0]   row,
  input  logic [COORD_BITS-1:0]   col,
  input  logic [HEIGHT_BITS-1:0]  height_in,
  input  logic                    q_full,
  output logic                    q_push,
  output cmd_t                    q_cmd,
  output logic [HEIGHT_BITS-1:0]  q_height
);

  localparam logic [12:0] MR = 13'(MAX_ROWS);
  localparam logic [12:0] MC = 13'(MAX_COLS);

  logic [BOUND_BITS-1:0] nr, nc;
  logic [BOUND_BITS-1:0] row_x, col_x, rr_x, cr_x;
  logic [BOUND_BITS-1:0] row_end, col_end;
  logic [BOUND_BITS-1:0] r_lo, r_hi, c_lo, c_hi;
  logic                  write_ok;

  // grid size in use, capped by the storage
  assign nr = ({4'b0, cfg.grid_rows} > MR) ? MR[BOUND_BITS-1:0] : {1'b0, cfg.grid_rows};
  assign nc = ({4'b0, cfg.grid_cols} > MC) ? MC[BOUND_BITS-1:0] : {1'b0, cfg.grid_cols};

  assign row_x = {1'b0, row};
  assign col_x = {1'b0, col};
  assign rr_x  = {2'b0, cfg.row_radius};
  assign cr_x  = {2'b0, cfg.col_radius};

  // window bounds clipped to the grid, upper bound exclusive
  assign row_end = row_x + rr_x;
  assign col_end = col_x + cr_x;
  assign r_lo    = (row_x >= rr_x) ? row_x - rr_x : '0;
  assign c_lo    = (col_x >= cr_x) ? col_x - cr_x : '0;
  assign r_hi    = (row_end < nr) ? row_end : nr;
  assign c_hi    = (col_end < nc) ? col_end : nc;

  assign write_ok = (row_x < nr) && (col_x < nc);

  // push one command per accepted transfer that has work to do
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && ((op == OP_QUERY) || write_ok);

  always_comb begin
    q_cmd.query = (op == OP_QUERY);
    q_cmd.r_hi  = r_hi;
    q_cmd.c_hi  = c_hi;
    if (op == OP_QUERY) begin
      q_cmd.r_lo = r_lo;
      q_cmd.c_lo = c_lo;
    end else begin
      q_cmd.r_lo = row_x;
      q_cmd.c_lo = col_x;
    end
  end

  assign q_height = height_in;

endmodule

FILE: rtl/core/hmwm_fifo.sv
// short command queue between front and back end
// depends on hmwm_pkg for its default depth

module hmwm_fifo import hmwm_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [PW:0]       count;

  assign full     = (count == (PW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/core/hmwm_back.sv
// back end: height store, window scan with running maximum, result register
// depends on hmwm_pkg

module hmwm_back import hmwm_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  cmd_t                   q_cmd,
  input  logic [HEIGHT_BITS-1:0] q_height,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [HEIGHT_BITS-1:0] out_data,
  output logic                   busy
);

  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_BITS = (HEIGHT_BITS > 10) ? HEIGHT_BITS : 10;
  localparam logic signed [ACC_BITS-1:0] SENT = ACC_BITS'(SENTINEL_Q88);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } back_state_t;

  back_state_t state, state_next;

  logic [HEIGHT_BITS-1:0] mem [DEPTH];
  logic [HEIGHT_BITS-1:0] rdata;
  logic                   rd_pend;

  logic [BOUND_BITS-1:0]  r, c, c_lo, r_hi, c_hi;
  logic signed [ACC_BITS-1:0] acc, rd_ext;

  logic          start_query, do_write, win_empty, last_col, last_row;
  logic [AW-1:0] waddr, raddr;

  assign q_pop       = (state == ST_IDLE) && !q_empty;
  assign start_query = q_pop && q_cmd.query;
  assign do_write    = q_pop && !q_cmd.query;
  assign win_empty   = (q_cmd.r_lo >= q_cmd.r_hi) || (q_cmd.c_lo >= q_cmd.c_hi);
  assign last_col    = (c + 1'b1 == c_hi);
  assign last_row    = (r + 1'b1 == r_hi);
  assign busy        = (state != ST_IDLE);

  // row-major cell address
  assign waddr = AW'(AW'(q_cmd.r_lo) * AW'(MAX_COLS)) + AW'(q_cmd.c_lo);
  assign raddr = AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);

  assign rd_ext = ACC_BITS'($signed(rdata));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_query) begin
          state_next = win_empty ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_col && last_row) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_SCAN);
      if ((state == ST_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan counters and running maximum
  always_ff @(posedge clk) begin
    if (start_query) begin
      c_lo <= q_cmd.c_lo;
      r_hi <= q_cmd.r_hi;
      c_hi <= q_cmd.c_hi;
      r    <= q_cmd.r_lo;
      c    <= q_cmd.c_lo;
      acc  <= SENT;
    end else begin
      if (state == ST_SCAN) begin
        if (last_col) begin
          c <= c_lo;
          r <= r + 1'b1;
        end else begin
          c <= c + 1'b1;
        end
      end
      if (rd_pend && (rd_ext > acc)) begin
        acc <= rd_ext;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && (!out_valid || out_ready)) begin
      out_data <= acc[HEIGHT_BITS-1:0];
    end
  end

  // height store, one write and one read per cycle
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[waddr] <= q_height;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/height_map_window_max.sv
// top level of the height map window maximum block: config registers,
// front end, command queue and back end; depends on hmwm_pkg and submodules
//
// Usage:
//   s_* carries input items. s_tuser is the kind: 0 stores height_in at
//   (row, col), 1 asks for the largest height in rows row-row_radius ..
//   row+row_radius-1 and cols col-col_radius .. col+col_radius-1, clipped
//   to the grid. Each query gives one transfer on m_*, writes give none.
//   An empty window answers -256 (-1.0 in Q8.8).
//   Config is written through cfg_we / cfg_index / cfg_data; the user must
//   write it only while the block is idle, as the block does not enforce it.
// Operation:
//   the back end reads the store once per cycle on a read port apart
//   from its write port. A write is stored as it leaves the queue, and the
//   back end stays idle for the next command; a query steps through
//   ST_SCAN, one window cell per cycle, then ST_DRAIN and ST_OUT, where
//   m_tvalid is registered; an empty window goes straight to ST_OUT.
//   A four-entry queue lets the front keep accepting while the back scans.
// Reset clears the queue, the scan state and the output valid and
// loads the config defaults; the height store is not cleared. When
// m_tready is low the result holds, the back end stops at its next result
// and s_tready drops once the queue is full.

module height_map_window_max import hmwm_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // row [8:0], col [17:9], height_in [17+HEIGHT_BITS:18], zero fill above
  input  logic [((2*COORD_BITS+HEIGHT_BITS+7)/8)*8-1:0] s_tdata,
  // op
  input  logic                                      s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // window peak [HEIGHT_BITS-1:0], zero fill above
  output logic [((HEIGHT_BITS+7)/8)*8-1:0]          m_tdata,
  input  logic                                      cfg_we,
  input  logic [1:0]                                cfg_index,
  input  logic [CFG_BITS-1:0]                       cfg_data
);

  localparam int OUT_W  = ((HEIGHT_BITS+7)/8)*8;
  localparam int Q_W    = $bits(cmd_t) + HEIGHT_BITS;
  localparam int ACC_W  = (HEIGHT_BITS > 10) ? HEIGHT_BITS : 10;

  cfg_t                   cfg;
  logic                   q_push, q_pop, q_full, q_empty, back_busy;
  cmd_t                   push_cmd, pop_cmd;
  logic [HEIGHT_BITS-1:0] push_height, pop_height, result;
  logic [Q_W-1:0]         pop_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_rows  <= RST_GRID_ROWS;
      cfg.grid_cols  <= RST_GRID_COLS;
      cfg.row_radius <= RST_ROW_RADIUS;
      cfg.col_radius <= RST_COL_RADIUS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS:  cfg.grid_rows  <= cfg_data;
        REG_GRID_COLS:  cfg.grid_cols  <= cfg_data;
        REG_ROW_RADIUS: cfg.row_radius <= cfg_data[RADIUS_BITS-1:0];
        REG_COL_RADIUS: cfg.col_radius <= cfg_data[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // item intake and classification
  hmwm_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_front (
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .op        (s_tuser),
    .row       (s_tdata[COORD_BITS-1:0]),
    .col       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .height_in (s_tdata[2*COORD_BITS+HEIGHT_BITS-1:2*COORD_BITS]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .q_height  (push_height)
  );

  // command queue
  hmwm_fifo #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_height, push_cmd}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_word),
    .empty     (q_empty)
  );

  assign pop_cmd    = pop_word[$bits(cmd_t)-1:0];
  assign pop_height = pop_word[Q_W-1:$bits(cmd_t)];

  // store, window scan and result register
  hmwm_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_height  (pop_height),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result),
    .busy      (back_busy)
  );

  assign m_tdata = OUT_W'(result);

  // checks
  logic signed [ACC_W-1:0] result_ext;
  assign result_ext = ACC_W'($signed(result));

  // a result never lies below the empty-window value
  a_result_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result_ext >= ACC_W'(SENTINEL_Q88)))
    else $error("window maximum below sentinel");

  // a new result needs a query in flight
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(back_busy))
    else $error("result transfer without back end activity");

  // the back end only starts work taken from the queue
  a_back_start: assert property (@(posedge clk) disable iff (rst)
    (!back_busy && q_empty) |=> !back_busy)
    else $error("back end started with empty queue");

endmodule
